FILE: rtl/assert_macros.svh
// Assertion macros used by the port-level checker of the sequence loss tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PLSL_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("plsl assertion failed");

// Next-cycle implication, disabled during reset.
`define PLSL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("plsl assertion failed");

`endif

FILE: rtl/plsl_pkg.sv
// Package with the types, codes and hash function of the sequence loss tracker.
package plsl_pkg;

   localparam int MAC_W      = 48;
   localparam int SEQ_W      = 32;
   localparam int STATUS_W   = 3;
   localparam int SLOT_OUT_W = 6;

   // The hash multiplies by 31 over six bytes; times 31 is a shift by 5 minus one copy.
   localparam int MAC_BYTES  = 6;
   localparam int HASH_SHIFT = 5;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_NEW     = 3'd0,
      ST_INORDER = 3'd1,
      ST_GAP     = 3'd2,
      ST_RESET   = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   // One received packet.
   typedef struct packed {
      logic [MAC_W-1:0] client_mac;
      logic [SEQ_W-1:0] sequence_req;
   } item_type;

   // One table slot as stored in a bucket row.
   typedef struct packed {
      logic             valid;
      logic [MAC_W-1:0] mac;
      logic [SEQ_W-1:0] last_sequence;
      logic [SEQ_W-1:0] lost_count;
   } slot_type;

   // One result item.
   typedef struct packed {
      status_type            status;
      logic [SLOT_OUT_W-1:0] entry_slot;
      logic [SEQ_W-1:0]      missing_added;
      logic [SEQ_W-1:0]      missing_total;
   } result_type;

   // Outcome of the slot update for one item.
   typedef struct packed {
      logic       write;
      result_type result;
   } upd_type;

   // Hash of the MAC, byte 0 taken from the top bits, 32-bit wrap.
   function automatic logic [31:0] mac_hash(input logic [MAC_W-1:0] mac);
      logic [31:0] h;
      h = '0;
      for (int b = 0; b < MAC_BYTES; b++) begin
         h = (h << HASH_SHIFT) - h + 32'(mac[MAC_W-1-8*b -: 8]);
      end
      return h;
   endfunction

endpackage

FILE: rtl/plsl_if.sv
// Valid/ready channel interfaces for packet items and result items.
interface plsl_req_if;
   logic                         valid;
   logic                         ready;
   logic [plsl_pkg::MAC_W-1:0]   client_mac;
   logic [plsl_pkg::SEQ_W-1:0]   sequence_req;

   modport source (output valid, client_mac, sequence_req, input ready);
   modport sink   (input valid, client_mac, sequence_req, output ready);
endinterface

interface plsl_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [plsl_pkg::STATUS_W-1:0]    status;
   logic [plsl_pkg::SLOT_OUT_W-1:0]  entry_slot;
   logic [plsl_pkg::SEQ_W-1:0]       missing_added;
   logic [plsl_pkg::SEQ_W-1:0]       missing_total;

   modport source (output valid, status, entry_slot, missing_added, missing_total,
                   input ready);
   modport sink   (input valid, status, entry_slot, missing_added, missing_total,
                   output ready);
endinterface

FILE: rtl/per_client_sequence_loss_tracker.sv
// Top level of the per-client sequence loss tracker. Each packet item carries a
// client MAC and a sequence number; the MAC is hashed into one of BUCKETS rows of
// WAYS slots held in an on-chip memory, the client's slot is found or claimed, and
// forward gaps add to a saturating missing count while a lower sequence clears it.
// One item is accepted per clock cycle and one result item leaves per cycle while
// the result side takes them; an item passes an input register, the hash, two
// modulo stages and the registered row read; the slot update sets the result register.
// The read-modify-write of a row takes one pass, and a row written by the item
// just ahead is forwarded from a bypass register. After reset a clearing pass
// empties the memory, one row a cycle, and no item is accepted until it ends.
// A stalled result holds the whole pipeline.
module per_client_sequence_loss_tracker #(
   parameter int BUCKETS = 16,
   parameter int WAYS    = 4
) (
   input logic        clock,
   input logic        reset,
   plsl_req_if.sink   req,
   plsl_rsp_if.source rsp
);

   localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

   typedef plsl_pkg::slot_type [WAYS-1:0] row_type;

   row_type slot_mem [BUCKETS];

   logic                 advance;
   logic                 req_ready;
   logic                 mem_we;
   logic                 clearing_ff;
   logic                 clearing_in;
   logic [BUCKET_W-1:0]  clr_idx_ff;
   logic [BUCKET_W-1:0]  clr_idx_in;

   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, e_valid_ff;
   plsl_pkg::item_type   req_item;
   plsl_pkg::item_type   a_item_ff, b_item_ff, c_item_ff, d_item_ff, e_item_ff;
   logic [BUCKET_W-1:0]  d_bucket;
   logic [BUCKET_W-1:0]  e_bucket_ff;
   row_type              rd_row_ff;
   row_type              e_row;
   row_type              upd_row;
   plsl_pkg::upd_type    upd;

   logic                 byp_valid_ff;
   logic [BUCKET_W-1:0]  byp_bucket_ff;
   row_type              byp_row_ff;

   logic                 rsp_valid_ff;
   plsl_pkg::result_type rsp_result_ff;

   // Pipeline moves when the result register is empty or being taken.
   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req_ready = advance && !clearing_ff;
   assign req.ready = req_ready;
   assign req_item  = '{client_mac: req.client_mac, sequence_req: req.sequence_req};

   // Clearing pass sequencing.
   always_comb begin
      clearing_in = clearing_ff;
      clr_idx_in  = clr_idx_ff;
      if (clearing_ff) begin
         if (clr_idx_ff == BUCKET_W'(BUCKETS - 1)) begin
            clearing_in = 1'b0;
         end else begin
            clr_idx_in = clr_idx_ff + 1'b1;
         end
      end
   end

   // Bucket selection, aligned with stage D.
   plsl_bucket_map #(
      .BUCKETS (BUCKETS)
   ) u_bucket_map (
      .clock  (clock),
      .en     (advance),
      .mac    (a_item_ff.client_mac),
      .bucket (d_bucket)
   );

   // Row seen by the update: forward the row written at the edge of the read.
   assign e_row = (byp_valid_ff && byp_bucket_ff == e_bucket_ff) ? byp_row_ff : rd_row_ff;

   plsl_slot_update #(
      .BUCKETS (BUCKETS),
      .WAYS    (WAYS)
   ) u_slot_update (
      .bucket  (e_bucket_ff),
      .item    (e_item_ff),
      .row_in  (e_row),
      .row_out (upd_row),
      .upd     (upd)
   );

   assign mem_we = advance && e_valid_ff && upd.write;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_idx_ff   <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         e_valid_ff   <= 1'b0;
         byp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clearing_ff <= clearing_in;
         clr_idx_ff  <= clr_idx_in;
         if (advance) begin
            a_valid_ff   <= req.valid && req_ready;
            b_valid_ff   <= a_valid_ff;
            c_valid_ff   <= b_valid_ff;
            d_valid_ff   <= c_valid_ff;
            e_valid_ff   <= d_valid_ff;
            byp_valid_ff <= mem_we;
            rsp_valid_ff <= e_valid_ff;
         end
      end
   end

   // Item payload pipeline, bypass row and result register.
   always_ff @(posedge clock) begin
      if (advance) begin
         a_item_ff     <= req_item;
         b_item_ff     <= a_item_ff;
         c_item_ff     <= b_item_ff;
         d_item_ff     <= c_item_ff;
         e_item_ff     <= d_item_ff;
         e_bucket_ff   <= d_bucket;
         byp_bucket_ff <= e_bucket_ff;
         byp_row_ff    <= upd_row;
         if (e_valid_ff) begin
            rsp_result_ff <= upd.result;
         end
      end
   end

   // Slot memory: one row write and one registered row read per cycle.
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         slot_mem[clr_idx_ff] <= '0;
      end else if (mem_we) begin
         slot_mem[e_bucket_ff] <= upd_row;
      end
      if (advance) begin
         rd_row_ff <= slot_mem[d_bucket];
      end
   end

   // Result channel.
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_result_ff.status;
   assign rsp.entry_slot    = rsp_result_ff.entry_slot;
   assign rsp.missing_added = rsp_result_ff.missing_added;
   assign rsp.missing_total = rsp_result_ff.missing_total;

endmodule

FILE: rtl/plsl_bucket_map.sv
// Three-stage pipeline that hashes a MAC and reduces the hash modulo the bucket count.
module plsl_bucket_map #(
   parameter int  BUCKETS  = 16,
   localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [plsl_pkg::MAC_W-1:0] mac,
   output logic [BUCKET_W-1:0]        bucket
);

   // Reciprocal of the bucket count scaled by 2^RED_SHIFT; the estimated
   // quotient is low by at most one, so one compare and subtract finishes it.
   localparam int          RED_SHIFT = 32 + $clog2(BUCKETS);
   localparam logic [32:0] RECIP     = 33'((64'd1 << RED_SHIFT) / 64'(BUCKETS));
   localparam int          R_W       = BUCKET_W + 1;

   logic [31:0]        h_ff;
   logic [64:0]        prod;
   logic [R_W-1:0]     q_in;
   logic [R_W-1:0]     q_ff;
   logic [R_W-1:0]     hc_ff;
   logic [R_W-1:0]     rem;
   logic [R_W-1:0]     red_in;
   logic [BUCKET_W-1:0] bucket_ff;

   // Quotient estimate; only its low bits matter for the remainder.
   always_comb begin
      prod = 65'(h_ff) * 65'(RECIP);
      q_in = R_W'(prod >> RED_SHIFT);
   end

   // Remainder below twice the bucket count, then one correction.
   always_comb begin
      rem    = R_W'(hc_ff - R_W'(q_ff * R_W'(BUCKETS)));
      red_in = (rem >= R_W'(BUCKETS)) ? R_W'(rem - R_W'(BUCKETS)) : rem;
   end

   // Stage registers, advanced together with the item pipeline.
   always_ff @(posedge clock) begin
      if (en) begin
         h_ff      <= plsl_pkg::mac_hash(mac);
         q_ff      <= q_in;
         hc_ff     <= h_ff[R_W-1:0];
         bucket_ff <= BUCKET_W'(red_in);
      end
   end

   assign bucket = bucket_ff;

endmodule

FILE: rtl/plsl_slot_update.sv
// Lookup, allocation and loss arithmetic for one packet against its bucket row.
module plsl_slot_update #(
   parameter int  BUCKETS  = 16,
   parameter int  WAYS     = 4,
   localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1
) (
   input  logic [BUCKET_W-1:0]            bucket,
   input  plsl_pkg::item_type             item,
   input  plsl_pkg::slot_type [WAYS-1:0]  row_in,
   output plsl_pkg::slot_type [WAYS-1:0]  row_out,
   output plsl_pkg::upd_type              upd
);

   logic                found;
   logic                have_free;
   logic [WAY_W-1:0]    found_way;
   logic [WAY_W-1:0]    free_way;
   logic [WAY_W-1:0]    sel_way;
   plsl_pkg::slot_type  cur;
   plsl_pkg::slot_type  nxt;
   logic [32:0]         next_last;
   logic                is_gap;
   logic [31:0]         gap_amount;
   logic [32:0]         sum;
   logic [31:0]         sat_sum;
   logic [31:0]         added;
   plsl_pkg::status_type status;

   // First matching valid way and first free way of the bucket.
   always_comb begin
      found     = 1'b0;
      have_free = 1'b0;
      found_way = '0;
      free_way  = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (row_in[w].valid) begin
            if (!found && row_in[w].mac == item.client_mac) begin
               found     = 1'b1;
               found_way = WAY_W'(w);
            end
         end else if (!have_free) begin
            have_free = 1'b1;
            free_way  = WAY_W'(w);
         end
      end
   end

   // Gap arithmetic against the stored last sequence.
   always_comb begin
      sel_way    = found ? found_way : free_way;
      cur        = row_in[sel_way];
      next_last  = {1'b0, cur.last_sequence} + 33'd1;
      is_gap     = {1'b0, item.sequence_req} > next_last;
      gap_amount = item.sequence_req - cur.last_sequence - 32'd1;
      sum        = {1'b0, cur.lost_count} + {1'b0, gap_amount};
      sat_sum    = sum[32] ? '1 : sum[31:0];
   end

   // New slot contents and status.
   always_comb begin
      nxt.valid         = 1'b1;
      nxt.mac           = item.client_mac;
      nxt.last_sequence = item.sequence_req;
      nxt.lost_count    = '0;
      added             = '0;
      status            = plsl_pkg::ST_NEW;
      if (found) begin
         nxt.lost_count = cur.lost_count;
         status         = plsl_pkg::ST_INORDER;
         if (cur.last_sequence != '0) begin
            if (is_gap) begin
               nxt.lost_count = sat_sum;
               added          = gap_amount;
               status         = plsl_pkg::ST_GAP;
            end else if (item.sequence_req < cur.last_sequence) begin
               nxt.lost_count = '0;
               status         = plsl_pkg::ST_RESET;
            end
         end
      end
   end

   // Row write-back and result; a full bucket leaves the row untouched.
   always_comb begin
      row_out   = row_in;
      upd.write = found || have_free;
      if (upd.write) begin
         row_out[sel_way]               = nxt;
         upd.result.status              = status;
         upd.result.entry_slot          =
            plsl_pkg::SLOT_OUT_W'(plsl_pkg::SLOT_OUT_W'(bucket) *
                                  plsl_pkg::SLOT_OUT_W'(WAYS)) +
            plsl_pkg::SLOT_OUT_W'(sel_way);
         upd.result.missing_added       = added;
         upd.result.missing_total       = nxt.lost_count;
      end else begin
         upd.result.status              = plsl_pkg::ST_FULL;
         upd.result.entry_slot          = '0;
         upd.result.missing_added       = '0;
         upd.result.missing_total       = '0;
      end
   end

endmodule

FILE: rtl/plsl_checker.sv
// Port-level checker for the sequence loss tracker and its bind statement.
`include "assert_macros.svh"

module plsl_port_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [plsl_pkg::STATUS_W-1:0]     rsp_status,
   input logic [plsl_pkg::SLOT_OUT_W-1:0]   rsp_entry_slot,
   input logic [plsl_pkg::SEQ_W-1:0]        rsp_missing_added,
   input logic [plsl_pkg::SEQ_W-1:0]        rsp_missing_total
);

   localparam int FIELDS_W = plsl_pkg::STATUS_W + plsl_pkg::SLOT_OUT_W + 2 * plsl_pkg::SEQ_W;

   logic [FIELDS_W-1:0] rsp_fields;
   logic                rsp_stall;
   logic                rsp_full;
   logic                rsp_gap;
   logic                rsp_new;
   logic                counts_zero;
   logic                gap_covered;

   // Result fields and the conditions that the assertions look at.
   assign rsp_fields  = {rsp_status, rsp_entry_slot, rsp_missing_added, rsp_missing_total};
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_full    = rsp_valid && rsp_status == plsl_pkg::ST_FULL;
   assign rsp_gap     = rsp_valid && rsp_status == plsl_pkg::ST_GAP;
   assign rsp_new     = rsp_valid && rsp_status == plsl_pkg::ST_NEW;
   assign counts_zero = rsp_missing_added == '0 && rsp_missing_total == '0;
   assign gap_covered = rsp_missing_added != '0 && rsp_missing_total >= rsp_missing_added;

   // A result item that is not taken stays offered with the same contents.
   `PLSL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_fields))

   // No result item right after reset.
   `PLSL_ASSERT_IMPL(a_quiet_after_reset, clock, reset, $past(reset), !rsp_valid)

   // A full bucket reports all other fields as zero.
   `PLSL_ASSERT_IMPL(a_full_zero, clock, reset, rsp_full, rsp_entry_slot == '0 && counts_zero)

   // A gap adds something, and the saturating total covers at least that.
   `PLSL_ASSERT_IMPL(a_gap_counts, clock, reset, rsp_gap, gap_covered)

   // A new client starts with nothing missing.
   `PLSL_ASSERT_IMPL(a_new_clean, clock, reset, rsp_new, counts_zero)

endmodule

bind per_client_sequence_loss_tracker plsl_port_checker u_plsl_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_status        (rsp.status),
   .rsp_entry_slot    (rsp.entry_slot),
   .rsp_missing_added (rsp.missing_added),
   .rsp_missing_total (rsp.missing_total)
);

FILE: verif/plsl_checker.sv
// Checker that predicts and compares the result items of the sequence loss tracker.
`timescale 1ns / 1ps

module plsl_checker #(
   parameter int BUCKETS = 16,
   parameter int WAYS    = 4
) (
   input  logic  clock,
   input  logic  reset,
   plsl_req_if   req_mon,
   plsl_rsp_if   rsp_mon,
   output int    fail_count,
   output int    pending_count
);

   localparam int SLOTS       = BUCKETS * WAYS;
   localparam int MAX_REPORTS = 10;

   // Shadow copy of the client table.
   bit                         slot_used    [SLOTS];
   logic [plsl_pkg::MAC_W-1:0] slot_addr    [SLOTS];
   logic [plsl_pkg::SEQ_W-1:0] slot_last    [SLOTS];
   logic [plsl_pkg::SEQ_W-1:0] slot_missing [SLOTS];

   // Results still owed by the block, oldest first.
   plsl_pkg::result_type owed_results[$];

   // Bucket of a MAC: h = h*31 + byte over six bytes, byte 0 on top, then modulo BUCKETS.
   function automatic int unsigned bucket_of(input logic [plsl_pkg::MAC_W-1:0] mac);
      logic [31:0] h;
      h = '0;
      for (int i = 0; i < plsl_pkg::MAC_BYTES; i++) begin
         h = h * 32'd31 + {24'd0, mac[8*(plsl_pkg::MAC_BYTES-1-i) +: 8]};
      end
      return h % 32'(BUCKETS);
   endfunction

   // Applies one packet to the shadow table and returns the result it should produce.
   function automatic plsl_pkg::result_type track_packet(
      input logic [plsl_pkg::MAC_W-1:0] mac,
      input logic [plsl_pkg::SEQ_W-1:0] seq);
      int                   base;
      int                   slot;
      int                   free_slot;
      bit                   found;
      bit                   have_free;
      logic [32:0]          sum;
      plsl_pkg::result_type r;
      base      = bucket_of(mac) * WAYS;
      slot      = 0;
      free_slot = 0;
      found     = 1'b0;
      have_free = 1'b0;
      r.status        = plsl_pkg::ST_INORDER;
      r.entry_slot    = '0;
      r.missing_added = '0;
      r.missing_total = '0;

      // Look for the client in its bucket and note the lowest free way.
      for (int w = 0; w < WAYS; w++) begin
         if (slot_used[base + w]) begin
            if (!found && slot_addr[base + w] == mac) begin
               found = 1'b1;
               slot  = base + w;
            end
         end else if (!have_free) begin
            have_free = 1'b1;
            free_slot = base + w;
         end
      end

      // A full bucket leaves the table untouched.
      if (!found && !have_free) begin
         r.status = plsl_pkg::ST_FULL;
         return r;
      end

      if (!found) begin
         slot               = free_slot;
         slot_used[slot]    = 1'b1;
         slot_addr[slot]    = mac;
         slot_last[slot]    = '0;
         slot_missing[slot] = '0;
         r.status           = plsl_pkg::ST_NEW;
      end else if (slot_last[slot] != '0) begin
         // Forward gap adds the skipped count, saturating; a lower sequence clears it.
         if ({1'b0, seq} > {1'b0, slot_last[slot]} + 33'd1) begin
            r.missing_added    = seq - slot_last[slot] - 32'd1;
            sum                = {1'b0, slot_missing[slot]} + {1'b0, r.missing_added};
            slot_missing[slot] = sum[32] ? '1 : sum[31:0];
            r.status           = plsl_pkg::ST_GAP;
         end else if (seq < slot_last[slot]) begin
            slot_missing[slot] = '0;
            r.status           = plsl_pkg::ST_RESET;
         end
      end

      slot_last[slot] = seq;
      r.entry_slot    = plsl_pkg::SLOT_OUT_W'(slot);
      r.missing_total = slot_missing[slot];
      return r;
   endfunction

   // Watch both channels: predict on every accepted packet, compare every accepted result.
   always @(posedge clock) begin
      plsl_pkg::result_type got;
      plsl_pkg::result_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_used[i] = 1'b0;
         end
         owed_results.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            owed_results.push_back(track_packet(req_mon.client_mac, req_mon.sequence_req));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.status        = plsl_pkg::status_type'(rsp_mon.status);
            got.entry_slot    = rsp_mon.entry_slot;
            got.missing_added = rsp_mon.missing_added;
            got.missing_total = rsp_mon.missing_total;
            if (owed_results.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("unexpected result item: status %0d slot %0d added %0h total %0h",
                           got.status, got.entry_slot, got.missing_added, got.missing_total);
               end
            end else begin
               want = owed_results.pop_front();
               if (got != want) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS) begin
                     $display("result mismatch: expected status %0d slot %0d added %0h total %0h",
                              want.status, want.entry_slot, want.missing_added,
                              want.missing_total);
                     $display("                 actual   status %0d slot %0d added %0h total %0h",
                              got.status, got.entry_slot, got.missing_added, got.missing_total);
                  end
               end
            end
         end
      end
      pending_count = owed_results.size();
   end

endmodule

FILE: verif/per_client_sequence_loss_tracker_tb.sv
// Testbench top for the sequence loss tracker: packet stimulus, result back-pressure, verdict.
`timescale 1ns / 1ps

module per_client_sequence_loss_tracker_tb;

   localparam int BUCKETS      = 16;
   localparam int WAYS         = 4;
   localparam int RANDOM_ITEMS = 2000;
   localparam int POOL_SIZE    = 40;
   localparam int GROUP_START  = 24;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int HOLD_AFTER   = 300;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;

   logic clock;
   logic reset;
   int   cycle_count;
   int   items_sent;
   int   fail_count;
   int   pending_count;
   int   send_quiet_left;

   // Known clients of the random part and the next in-order sequence of each.
   logic [plsl_pkg::MAC_W-1:0] client_pool [POOL_SIZE];
   logic [plsl_pkg::SEQ_W-1:0] next_seq    [POOL_SIZE];

   plsl_req_if req_bus ();
   plsl_rsp_if rsp_bus ();

   per_client_sequence_loss_tracker #(
      .BUCKETS (BUCKETS),
      .WAYS    (WAYS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   plsl_checker #(
      .BUCKETS (BUCKETS),
      .WAYS    (WAYS)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // 12 ns clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL per_client_sequence_loss_tracker");
         $finish;
      end
   end

   function automatic logic [plsl_pkg::MAC_W-1:0] random_mac();
      logic [63:0] v;
      v = {$urandom(), $urandom()};
      return v[plsl_pkg::MAC_W-1:0];
   endfunction

   // Idle cycles after an item: mostly none or short, a few long, with idle-free stretches.
   function automatic int send_gap();
      int r;
      r = $urandom_range(0, 99);
      if (send_quiet_left > 0) begin
         send_quiet_left--;
         return 0;
      end
      if (r < 3) begin
         send_quiet_left = $urandom_range(30, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Offers one packet item and holds it until the block takes it.
   task automatic send_packet(input logic [plsl_pkg::MAC_W-1:0] mac,
                              input logic [plsl_pkg::SEQ_W-1:0] seq);
      int gap;
      req_bus.valid        <= 1'b1;
      req_bus.client_mac   <= mac;
      req_bus.sequence_req <= seq;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
      gap = send_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Result side: random stalls, idle-free stretches, and one long hold-off that fills the block.
   initial begin
      int  len;
      int  r;
      bit  held;
      held = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && items_sent >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
               rsp_bus.ready <= 1'b1;
               len = $urandom_range(30, 80);
            end else if (r < 60) begin
               rsp_bus.ready <= 1'b1;
               len = $urandom_range(1, 4);
            end else if (r < 90) begin
               rsp_bus.ready <= 1'b0;
               len = $urandom_range(1, 3);
            end else if (r < 97) begin
               rsp_bus.ready <= 1'b0;
               len = $urandom_range(4, 10);
            end else begin
               rsp_bus.ready <= 1'b0;
               len = $urandom_range(20, 60);
            end
            repeat (len) @(posedge clock);
         end
      end
   end

   // Packet stimulus and verdict.
   initial begin
      logic [plsl_pkg::MAC_W-1:0] grp_base;
      logic [plsl_pkg::SEQ_W-1:0] seq;
      int                         pick;
      int                         r;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.client_mac   <= '0;
      req_bus.sequence_req <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: new client, zero last sequence, repeat, next, gap, lower sequence.
      send_packet(48'h0000_0000_0000, 32'd0);
      send_packet(48'h0000_0000_0000, 32'd5);
      send_packet(48'h0000_0000_0000, 32'd5);
      send_packet(48'h0000_0000_0000, 32'd6);
      send_packet(48'h0000_0000_0000, 32'd10);
      send_packet(48'h0000_0000_0000, 32'd2);
      send_packet(48'h0000_0000_0000, 32'hFFFF_FFFF);
      send_packet(48'h0000_0000_0000, 32'd1);
      // Largest MAC, largest possible gap, and a drop back to zero.
      send_packet(48'hFFFF_FFFF_FFFF, 32'd1);
      send_packet(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      send_packet(48'hFFFF_FFFF_FFFF, 32'd0);
      // Five clients whose last byte differs by multiples of 16 share a bucket: table full.
      for (int k = 0; k < 5; k++) begin
         send_packet({40'h01_0203_0405, 4'(k), 4'h0}, 32'd7);
      end
      send_packet({40'h01_0203_0405, 4'd0, 4'h0}, 32'd9);
      send_packet({40'h01_0203_0405, 4'd4, 4'h0}, 32'd9);

      // Client pool: random MACs plus two groups of eight that collide in one bucket each.
      for (int i = 0; i < POOL_SIZE; i++) begin
         if (i < GROUP_START) begin
            client_pool[i] = random_mac();
         end else begin
            if ((i - GROUP_START) % 8 == 0) grp_base = random_mac();
            client_pool[i] = {grp_base[plsl_pkg::MAC_W-1:8], 4'(i % 8), grp_base[3:0]};
         end
         r = $urandom_range(0, 99);
         if (r < 30) next_seq[i] = $urandom_range(0, 3);
         else if (r < 80) next_seq[i] = $urandom_range(0, 1000);
         else next_seq[i] = $urandom();
      end

      // Random part: mostly in-order streams per client, with gaps, repeats, drops and noise.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, POOL_SIZE - 1);
         r    = $urandom_range(0, 99);
         if ($urandom_range(0, 99) < 2) begin
            client_pool[pick] = random_mac();
            next_seq[pick]    = $urandom_range(0, 100);
         end
         if (r >= 95) begin
            send_packet(random_mac(), $urandom());
         end else begin
            if (r < 55) seq = next_seq[pick];
            else if (r < 67) seq = next_seq[pick] + $urandom_range(1, 20);
            else if (r < 72) seq = next_seq[pick] + $urandom_range(21, 100000);
            else if (r < 80) seq = next_seq[pick] - 32'd1;
            else if (r < 88) seq = (next_seq[pick] == '0) ? '0 :
                                   $urandom_range(0, next_seq[pick] - 32'd1);
            else seq = $urandom();
            send_packet(client_pool[pick], seq);
            next_seq[pick] = seq + 32'd1;
         end
      end
      req_bus.valid <= 1'b0;

      // Drain every owed result, then let the pipeline settle.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS per_client_sequence_loss_tracker");
      end else begin
         $display("FAIL per_client_sequence_loss_tracker");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/plsl_pkg.sv
rtl/plsl_if.sv
rtl/plsl_bucket_map.sv
rtl/plsl_slot_update.sv
rtl/per_client_sequence_loss_tracker.sv
rtl/plsl_checker.sv
verif/plsl_checker.sv
verif/per_client_sequence_loss_tracker_tb.sv
